// ----- sv/jsu_pkg.sv -----
// shared types, codes and constants of the json string unescaper
// used by the front decoder, the entry queue, the utf-8 back end and the top level
package jsu_pkg;

  localparam int DEPTH_DEFAULT = 4;
  localparam int CP_W          = 21;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_HEX1,
    MODE_PAIR_BS,
    MODE_PAIR_U,
    MODE_HEX2,
    MODE_HALT
  } mode_t;

  typedef enum logic [3:0] {
    ST_RUNNING   = 4'd0,
    ST_CLOSED    = 4'd1,
    ST_UNCLOSED  = 4'd2,
    ST_CONTROL   = 4'd3,
    ST_END_ESC   = 4'd4,
    ST_BAD_ESC   = 4'd5,
    ST_HEX_SHORT = 4'd6,
    ST_NOT_HEX   = 4'd7,
    ST_LONE_LOW  = 4'd8,
    ST_LONE_HIGH = 4'd9
  } status_t;

  // raw byte, code point to encode, or end status
  typedef enum logic [1:0] {
    ENT_RAW,
    ENT_CP,
    ENT_STATUS
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CP_W-1:0]   cp;
    status_t           status;
  } entry_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [CP_W-1:0] PLANE1 = 21'h10000;

  // bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
    return v;
  endfunction

endpackage

// ----- sv/jsu_front.sv -----
// front decoder: takes text bytes, tracks escape and surrogate state,
// pushes one queue entry per byte at most; uses jsu_pkg
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // text_ends
  input  logic       queue_full,
  output logic       push,
  output entry_t     push_entry
);

  mode_t       mode, mode_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] hex_acc, hex_acc_next;
  logic [15:0] pending_high, pending_high_next;
  logic        bad_seen, bad_seen_next;

  logic            accept;
  logic [4:0]      hex_v;
  logic            digit_bad;
  logic [15:0]     digit_acc;
  logic            any_bad;
  logic            digit_final;
  logic            unit_low;
  logic            unit_high;
  logic [CP_W-1:0] pair_cp;

  assign s_tready    = !queue_full;
  assign accept      = s_tvalid && s_tready;
  assign hex_v       = hex_value(s_tdata);
  assign digit_bad   = hex_v[4];
  assign digit_acc   = {hex_acc[11:0], (digit_bad ? 4'h0 : hex_v[3:0])};
  assign any_bad     = bad_seen || digit_bad;
  assign digit_final = (digit_count == 2'd3);
  assign unit_low    = (digit_acc >= LOW_FIRST) && (digit_acc <= LOW_LAST);
  assign unit_high   = (digit_acc >= HIGH_FIRST) && (digit_acc <= HIGH_LAST);
  assign pair_cp     = {1'b0, pending_high[9:0], digit_acc[9:0]} + PLANE1;

  // next state
  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    hex_acc_next      = hex_acc;
    pending_high_next = pending_high;
    bad_seen_next     = bad_seen;
    if (accept) begin
      case (mode)
        MODE_IDLE: begin
          if (!s_tlast) mode_next = MODE_STRING;
        end
        MODE_STRING: begin
          if (s_tlast || s_tdata == CH_QUOTE || s_tdata < CH_SPACE) mode_next = MODE_HALT;
          else if (s_tdata == CH_BSLASH) mode_next = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          if (s_tlast) begin
            mode_next = MODE_HALT;
          end else begin
            case (s_tdata)
              CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                mode_next = MODE_STRING;
              end
              CH_U: begin
                mode_next        = MODE_HEX1;
                digit_count_next = 2'd0;
                hex_acc_next     = 16'h0;
                bad_seen_next    = 1'b0;
              end
              default: mode_next = MODE_HALT;
            endcase
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (s_tlast) begin
            mode_next = MODE_HALT;
          end else begin
            hex_acc_next  = digit_acc;
            bad_seen_next = any_bad;
            if (!digit_final) begin
              digit_count_next = digit_count + 2'd1;
            end else begin
              digit_count_next = 2'd0;
              if (any_bad) mode_next = MODE_HALT;
              else if (mode == MODE_HEX1) begin
                if (unit_low) mode_next = MODE_HALT;
                else if (unit_high) begin
                  mode_next         = MODE_PAIR_BS;
                  pending_high_next = digit_acc;
                end else mode_next = MODE_STRING;
              end else begin
                mode_next = unit_low ? MODE_STRING : MODE_HALT;
              end
            end
          end
        end
        MODE_PAIR_BS: begin
          mode_next = (s_tlast || s_tdata != CH_BSLASH) ? MODE_HALT : MODE_PAIR_U;
        end
        MODE_PAIR_U: begin
          if (s_tlast || s_tdata != CH_U) begin
            mode_next = MODE_HALT;
          end else begin
            mode_next        = MODE_HEX2;
            digit_count_next = 2'd0;
            hex_acc_next     = 16'h0;
            bad_seen_next    = 1'b0;
          end
        end
        MODE_HALT: begin
          if (s_tlast) mode_next = MODE_IDLE;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  // queue entry for this byte
  always_comb begin
    push              = 1'b0;
    push_entry.kind   = ENT_RAW;
    push_entry.cp     = {{(CP_W-8){1'b0}}, s_tdata};
    push_entry.status = ST_RUNNING;
    if (accept) begin
      case (mode)
        MODE_STRING: begin
          push = 1'b1;
          if (s_tlast) begin
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_UNCLOSED;
          end else if (s_tdata == CH_QUOTE) begin
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_CLOSED;
          end else if (s_tdata < CH_SPACE) begin
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_CONTROL;
          end else if (s_tdata == CH_BSLASH) begin
            push = 1'b0;
          end
        end
        MODE_ESCAPE: begin
          push = 1'b1;
          if (s_tlast) begin
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_END_ESC;
          end else begin
            case (s_tdata)
              CH_QUOTE, CH_BSLASH, CH_SLASH: ;
              CH_B: push_entry.cp = CP_W'(8'h08);
              CH_F: push_entry.cp = CP_W'(8'h0C);
              CH_N: push_entry.cp = CP_W'(8'h0A);
              CH_R: push_entry.cp = CP_W'(8'h0D);
              CH_T: push_entry.cp = CP_W'(8'h09);
              CH_U: push = 1'b0;
              default: begin
                push_entry.kind   = ENT_STATUS;
                push_entry.status = ST_BAD_ESC;
              end
            endcase
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (s_tlast) begin
            push              = 1'b1;
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_HEX_SHORT;
          end else if (digit_final) begin
            push = 1'b1;
            if (any_bad) begin
              push_entry.kind   = ENT_STATUS;
              push_entry.status = ST_NOT_HEX;
            end else if (mode == MODE_HEX1) begin
              if (unit_low) begin
                push_entry.kind   = ENT_STATUS;
                push_entry.status = ST_LONE_LOW;
              end else if (unit_high) begin
                push = 1'b0;
              end else begin
                push_entry.kind = ENT_CP;
                push_entry.cp   = CP_W'(digit_acc);
              end
            end else if (unit_low) begin
              push_entry.kind = ENT_CP;
              push_entry.cp   = pair_cp;
            end else begin
              push_entry.kind   = ENT_STATUS;
              push_entry.status = ST_LONE_HIGH;
            end
          end
        end
        MODE_PAIR_BS: begin
          if (s_tlast || s_tdata != CH_BSLASH) begin
            push              = 1'b1;
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_LONE_HIGH;
          end
        end
        MODE_PAIR_U: begin
          if (s_tlast || s_tdata != CH_U) begin
            push              = 1'b1;
            push_entry.kind   = ENT_STATUS;
            push_entry.status = ST_LONE_HIGH;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      digit_count  <= 2'd0;
      hex_acc      <= 16'h0;
      pending_high <= 16'h0;
      bad_seen     <= 1'b0;
    end else begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      hex_acc      <= hex_acc_next;
      pending_high <= pending_high_next;
      bad_seen     <= bad_seen_next;
    end
  end

endmodule

// ----- sv/jsu_queue.sv -----
// short entry queue between the front decoder and the utf-8 back end
// uses jsu_pkg for the entry type
module jsu_queue import jsu_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/jsu_back.sv -----
// back end: expands each queue entry into one to four result bytes
// behind an output register; uses jsu_pkg
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [12:9] status
  output logic        m_tlast    // last
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic [7:0] cur_byte;
  logic       cur_valid;
  logic       load;
  logic       at_last;

  always_comb begin
    last_idx  = 2'd0;
    cur_byte  = 8'h00;
    cur_valid = 1'b1;
    case (head.kind)
      ENT_RAW: cur_byte = head.cp[7:0];
      ENT_STATUS: cur_valid = 1'b0;
      ENT_CP: begin
        if (head.cp < 21'h80) begin
          cur_byte = head.cp[7:0];
        end else if (head.cp < 21'h800) begin
          last_idx = 2'd1;
          cur_byte = (idx == 2'd0) ? {3'b110, head.cp[10:6]} : {2'b10, head.cp[5:0]};
        end else if (head.cp < PLANE1) begin
          last_idx = 2'd2;
          case (idx)
            2'd0:    cur_byte = {4'b1110, head.cp[15:12]};
            2'd1:    cur_byte = {2'b10, head.cp[11:6]};
            default: cur_byte = {2'b10, head.cp[5:0]};
          endcase
        end else begin
          last_idx = 2'd3;
          case (idx)
            2'd0:    cur_byte = {5'b11110, head.cp[20:18]};
            2'd1:    cur_byte = {2'b10, head.cp[17:12]};
            2'd2:    cur_byte = {2'b10, head.cp[11:6]};
            default: cur_byte = {2'b10, head.cp[5:0]};
          endcase
        end
      end
      default: cur_valid = 1'b0;
    endcase
  end

  assign load    = !m_tvalid || m_tready;
  assign at_last = (idx == last_idx);
  assign pop     = load && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, head.status, cur_valid, cur_byte};
      m_tlast <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ----- sv/json_string_unescape_utf8_top.sv -----
// json string literal unescaper producing utf-8, top level
// ties jsu_front, jsu_queue and jsu_back together; uses jsu_pkg
//
// input channel s_*: one text byte per request in s_tdata[7:0]; s_tlast high
// means the text has ended and no byte is carried. the first byte after idle
// is taken as the opening quote.
// output channel m_*: one result per request; m_tdata holds out_byte [7:0],
// byte_valid [8] and status [12:9]; m_tlast marks the last result that one
// input request caused. a closing quote or an error gives one result with
// byte_valid low and the status code, after which bytes are dropped until
// s_tlast returns the block to idle.
// throughput: one input request per cycle and one result per cycle while the
// receiver holds m_tready high. a \u escape expands to up to four results,
// one per cycle, from the utf-8 back end; the entry queue (QUEUE_DEPTH
// entries) absorbs those bursts and the input stalls only when it fills.
// each result passes through the entry queue and then the output register.
// reset clears the decoder to idle and empties queue and output register.
// when the receiver stalls the output register holds its result, the queue
// fills, then s_tready drops.
module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // text_ends
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [12:9] status
  output logic        m_tlast    // last
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   head_valid;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- sv/jsu_checker.sv -----
// port-level checks of the json string unescaper output channel
// bound to json_string_unescape_utf8_top; no package needed
module jsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // nothing presented right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result presented after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a status result carries no byte and ends its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tlast && m_tdata[7:0] == 8'h00 && m_tdata[12:9] != 4'd0)
    else $error("status result malformed");

  // decoded bytes always report running status
  a_byte_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[12:9] == 4'd0)
    else $error("decoded byte with nonzero status");

  // status in range and padding zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:9] <= 4'd9 && m_tdata[15:13] == 3'b000)
    else $error("status out of range or padding set");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
